FILE: hdl/hbleg_pkg.sv
// Types, constants, microcode table and arithmetic helpers of the half-bridge leg step unit.
package hbleg_pkg;

  localparam int unsigned TMP_DEPTH = 32;
  localparam int unsigned TMP_AW    = 5;
  localparam int unsigned PC_W      = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 63;

  typedef logic signed [63:0]  q_t;
  typedef logic [CFG_W-1:0]    ucfg_t;
  typedef logic [TMP_AW-1:0]   tmp_t;
  typedef logic [PC_W-1:0]     pc_t;
  typedef logic [2:0]          step_t;

  typedef struct packed {
    q_t   positive_node_voltage;
    q_t   negative_node_voltage;
    q_t   ground_node_voltage;
    q_t   output_node_voltage;
    logic gate_upper;
    logic gate_lower;
  } hbleg_in_t;

  typedef struct packed {
    q_t cap_pos_voltage;
    q_t cap_neg_voltage;
    q_t leg_current;
    q_t pos_source_contribution;
    q_t neg_source_contribution;
  } hbleg_out_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TIME_STEP       = 3'd0,
    CFG_INDUCTANCE      = 3'd1,
    CFG_INV_INDUCTANCE  = 3'd2,
    CFG_LEG_RESISTANCE  = 3'd3,
    CFG_DIODE_THRESHOLD = 3'd4,
    CFG_SOURCE_GAIN     = 3'd5,
    CFG_LOAD_GAIN       = 3'd6
  } cfg_idx_e;

  localparam ucfg_t RST_ONE         = 63'd4294967296;
  localparam ucfg_t RST_SOURCE_GAIN = 63'd42949672960000;
  localparam q_t    RST_THRESHOLD   = 64'sd4294967296;

  localparam q_t Q_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam q_t Q_MIN  = 64'sh8000_0000_0000_0000;
  localparam q_t Q_HALF = 64'sd2147483648;
  localparam q_t Q_RSW  = 64'sd429497;
  localparam q_t Q_RSWH = 64'sd214748;
  localparam q_t Q_GSW  = 64'sd42949672960000;

  // rounding offsets: half LSB, plus one to finish a two's complement negate
  localparam logic [127:0] RND_POS = 128'h8000_0000;
  localparam logic [127:0] RND_NEG = 128'h8000_0001;

  localparam step_t MUL_LAST_STEP = 3'd4;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DECIDE,
    OP_WR_CAP,
    OP_WR_LEG,
    OP_WR_SRC,
    OP_DONE
  } op_e;

  typedef enum logic [4:0] {
    SRC_VP, SRC_VN, SRC_VG, SRC_VA,
    SRC_VCP, SRC_VCN, SRC_I0, SRC_SLP,
    SRC_TS, SRC_L, SRC_IL, SRC_R, SRC_SG, SRC_LG,
    SRC_HALF, SRC_RSW, SRC_RSWH, SRC_GSW, SRC_ZERO,
    SRC_TMP,
    SRC_SEL_IP, SRC_SEL_IN, SRC_SEL_VSUM, SRC_SEL_COEF, SRC_SEL_I0
  } src_e;

  typedef struct packed {
    src_e kind;
    tmp_t tmp;
  } opnd_t;

  typedef struct packed {
    op_e   op;
    opnd_t a;
    opnd_t b;
    tmp_t  dst;
  } uop_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_READ, ST_EXEC, ST_MLOAD, ST_MPP, ST_MFIN, ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic  load_in;
    logic  exec;
    logic  mul_load;
    logic  mul_step;
    logic  mul_fin;
    logic  load_out;
    step_t step;
    uop_t  uop;
  } cmd_t;

  // scratch slots; the early ones are reused once their first values are dead
  localparam tmp_t T_VCPG = tmp_t'(0);
  localparam tmp_t T_VCNG = tmp_t'(1);
  localparam tmp_t T_M1   = tmp_t'(2);
  localparam tmp_t T_M2   = tmp_t'(3);
  localparam tmp_t T_X    = tmp_t'(4);
  localparam tmp_t T_VSP  = tmp_t'(5);
  localparam tmp_t T_S    = tmp_t'(6);
  localparam tmp_t T_H    = tmp_t'(7);
  localparam tmp_t T_H2   = tmp_t'(8);
  localparam tmp_t T_Q    = tmp_t'(9);
  localparam tmp_t T_VST  = tmp_t'(10);
  localparam tmp_t T_ROL  = tmp_t'(11);
  localparam tmp_t T_D1   = tmp_t'(12);
  localparam tmp_t T_D2   = tmp_t'(13);
  localparam tmp_t T_P    = tmp_t'(14);
  localparam tmp_t T_CF   = tmp_t'(15);
  localparam tmp_t T_A1   = tmp_t'(16);
  localparam tmp_t T_IPS  = tmp_t'(17);
  localparam tmp_t T_A2   = tmp_t'(18);
  localparam tmp_t T_INS  = tmp_t'(19);
  localparam tmp_t T_PA   = tmp_t'(20);
  localparam tmp_t T_PB   = tmp_t'(21);
  localparam tmp_t T_PM   = tmp_t'(22);
  localparam tmp_t T_PS   = tmp_t'(23);
  localparam tmp_t T_PC   = tmp_t'(24);
  localparam tmp_t T_VCPN = tmp_t'(25);
  localparam tmp_t T_NA   = tmp_t'(26);
  localparam tmp_t T_NB   = tmp_t'(27);
  localparam tmp_t T_NM   = tmp_t'(28);
  localparam tmp_t T_NS   = tmp_t'(29);
  localparam tmp_t T_NC   = tmp_t'(30);
  localparam tmp_t T_VCNN = tmp_t'(31);
  localparam tmp_t T_D    = tmp_t'(2);
  localparam tmp_t T_E    = tmp_t'(3);
  localparam tmp_t T_F    = tmp_t'(4);
  localparam tmp_t T_SLP  = tmp_t'(5);
  localparam tmp_t T_G    = tmp_t'(6);
  localparam tmp_t T_ILA  = tmp_t'(7);
  localparam tmp_t T_O3   = tmp_t'(8);
  localparam tmp_t T_O4   = tmp_t'(9);

  function automatic opnd_t os(input src_e k);
    opnd_t o;
    o.kind = k;
    o.tmp  = T_VCPG;
    return o;
  endfunction

  function automatic opnd_t ot(input tmp_t i);
    opnd_t o;
    o.kind = SRC_TMP;
    o.tmp  = i;
    return o;
  endfunction

  function automatic uop_t mk(input op_e op, input opnd_t a, input opnd_t b, input tmp_t dst);
    uop_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = dst;
    return u;
  endfunction

  function automatic uop_t uop_at(input pc_t pc);
    uop_t u;
    unique case (pc)
      6'd0:  u = mk(OP_ADD, os(SRC_VCP), os(SRC_VG), T_VCPG);
      6'd1:  u = mk(OP_ADD, os(SRC_VCN), os(SRC_VG), T_VCNG);
      6'd2:  u = mk(OP_MUL, os(SRC_L), os(SRC_SLP), T_M1);
      6'd3:  u = mk(OP_MUL, os(SRC_I0), os(SRC_R), T_M2);
      6'd4:  u = mk(OP_ADD, ot(T_M1), ot(T_M2), T_X);
      6'd5:  u = mk(OP_ADD, ot(T_X), os(SRC_VA), T_VSP);
      6'd6:  u = mk(OP_ADD, os(SRC_VCP), os(SRC_VCN), T_S);
      6'd7:  u = mk(OP_MUL, os(SRC_HALF), ot(T_S), T_H);
      6'd8:  u = mk(OP_ADD, ot(T_H), os(SRC_VG), T_H2);
      6'd9:  u = mk(OP_MUL, os(SRC_RSWH), os(SRC_I0), T_Q);
      6'd10: u = mk(OP_SUB, ot(T_H2), ot(T_Q), T_VST);
      6'd11: u = mk(OP_MUL, os(SRC_R), os(SRC_IL), T_ROL);
      6'd12: u = mk(OP_SUB, ot(T_VSP), ot(T_VCPG), T_D1);
      6'd13: u = mk(OP_SUB, ot(T_VCNG), ot(T_VSP), T_D2);
      6'd14: u = mk(OP_DECIDE, ot(T_D1), ot(T_D2), T_VCPG);
      6'd15: u = mk(OP_MUL, os(SRC_RSW), os(SRC_IL), T_P);
      6'd16: u = mk(OP_ADD, ot(T_P), ot(T_ROL), T_CF);
      6'd17: u = mk(OP_SUB, ot(T_VCPG), ot(T_VST), T_A1);
      6'd18: u = mk(OP_MUL, os(SRC_GSW), ot(T_A1), T_IPS);
      6'd19: u = mk(OP_SUB, ot(T_VCNG), ot(T_VST), T_A2);
      6'd20: u = mk(OP_MUL, os(SRC_GSW), ot(T_A2), T_INS);
      6'd21: u = mk(OP_SUB, os(SRC_VP), os(SRC_VCP), T_PA);
      6'd22: u = mk(OP_SUB, ot(T_PA), os(SRC_VG), T_PB);
      6'd23: u = mk(OP_MUL, os(SRC_SG), ot(T_PB), T_PM);
      6'd24: u = mk(OP_ADD, os(SRC_VCP), ot(T_PM), T_PS);
      6'd25: u = mk(OP_MUL, os(SRC_LG), os(SRC_SEL_IP), T_PC);
      6'd26: u = mk(OP_SUB, ot(T_PS), ot(T_PC), T_VCPN);
      6'd27: u = mk(OP_SUB, os(SRC_VN), os(SRC_VCN), T_NA);
      6'd28: u = mk(OP_SUB, ot(T_NA), os(SRC_VG), T_NB);
      6'd29: u = mk(OP_MUL, os(SRC_SG), ot(T_NB), T_NM);
      6'd30: u = mk(OP_ADD, os(SRC_VCN), ot(T_NM), T_NS);
      6'd31: u = mk(OP_MUL, os(SRC_LG), os(SRC_SEL_IN), T_NC);
      6'd32: u = mk(OP_SUB, ot(T_NS), ot(T_NC), T_VCNN);
      6'd33: u = mk(OP_SUB, os(SRC_SEL_VSUM), os(SRC_VA), T_D);
      6'd34: u = mk(OP_MUL, os(SRC_IL), ot(T_D), T_E);
      6'd35: u = mk(OP_MUL, os(SRC_SEL_COEF), os(SRC_SEL_I0), T_F);
      6'd36: u = mk(OP_SUB, ot(T_E), ot(T_F), T_SLP);
      6'd37: u = mk(OP_MUL, os(SRC_TS), ot(T_SLP), T_G);
      6'd38: u = mk(OP_ADD, os(SRC_SEL_I0), ot(T_G), T_ILA);
      6'd39: u = mk(OP_MUL, ot(T_VCPN), os(SRC_GSW), T_O3);
      6'd40: u = mk(OP_MUL, ot(T_VCNN), os(SRC_GSW), T_O4);
      6'd41: u = mk(OP_WR_CAP, ot(T_VCPN), ot(T_VCNN), T_VCPG);
      6'd42: u = mk(OP_WR_LEG, ot(T_ILA), ot(T_SLP), T_VCPG);
      6'd43: u = mk(OP_WR_SRC, ot(T_O3), ot(T_O4), T_VCPG);
      default: u = mk(OP_DONE, os(SRC_ZERO), os(SRC_ZERO), T_VCPG);
    endcase
    return u;
  endfunction

  // saturating add or subtract on Q32.32
  function automatic q_t sat_addsub(input q_t a, input q_t b, input logic sub);
    logic [64:0] s;
    s = sub ? ({a[63], a} - {b[63], b}) : ({a[63], a} + {b[63], b});
    if (s[64] != s[63]) begin
      return s[64] ? Q_MIN : Q_MAX;
    end
    return q_t'(s[63:0]);
  endfunction

endpackage

FILE: hdl/hbleg_ram.sv
// Generic one-write, two-read RAM with registered read data.
module hbleg_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_a_q;
  logic [WIDTH-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

FILE: hdl/hbleg_ctrl.sv
// Microcode sequencer: walks the step program and drives the datapath commands.
module hbleg_ctrl import hbleg_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  pc_t         pc_q, pc_d;
  step_t       step_q, step_d;
  logic        out_valid_q, out_valid_d;
  uop_t        uop;

  assign uop = uop_at(pc_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pc_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pc_q        <= pc_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    pc_d          = pc_q;
    step_d        = step_q;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.uop     = uop;
    cmd_o.step    = step_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          pc_d          = '0;
          state_d       = ST_READ;
        end
      end
      ST_READ: begin
        if (uop.op == OP_DONE) begin
          state_d = ST_DONE;
        end else if (uop.op == OP_MUL) begin
          state_d = ST_MLOAD;
        end else begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        pc_d       = pc_q + 1'b1;
        state_d    = ST_READ;
      end
      ST_MLOAD: begin
        cmd_o.mul_load = 1'b1;
        step_d         = '0;
        state_d        = ST_MPP;
      end
      ST_MPP: begin
        cmd_o.mul_step = 1'b1;
        step_d         = step_q + 1'b1;
        if (step_q == MUL_LAST_STEP) begin
          state_d = ST_MFIN;
        end
      end
      ST_MFIN: begin
        cmd_o.mul_fin = 1'b1;
        pc_d          = pc_q + 1'b1;
        state_d       = ST_READ;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hdl/hbleg_dp.sv
// Datapath: config and state registers, scratch RAM, saturating adder and shared multiplier.
module hbleg_dp import hbleg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  input  hbleg_in_t            in_data_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i,
  output hbleg_out_t           out_data_o
);

  hbleg_in_t  in_q;
  hbleg_out_t out_q;
  ucfg_t      ts_q, l_q, il_q, r_q, sg_q, lg_q;
  q_t         vth_q;
  q_t         vcp_q, vcn_q, i0_q, slp_q, srcp_q, srcn_q;
  logic       up_on_q, lo_on_q, cu_q, cl_q;
  logic [63:0]  a_mag_q, b_mag_q, prod_q;
  logic         neg_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;

  opnd_t ra, rb;
  q_t    ram_a, ram_b, va, vb, alu_res, mul_res;
  logic  ram_we;
  logic [31:0]  a_h, b_h;
  logic [127:0] pp_ext, fin_v;
  logic         du, dl;

  // map case-dependent operands onto a plain source or a scratch slot
  function automatic opnd_t resolve(input opnd_t o, input logic cu, input logic cl);
    opnd_t r;
    r = o;
    unique case (o.kind)
      SRC_SEL_IP: begin
        if (cu && cl) r = ot(T_IPS);
        else if (cu)  r = os(SRC_I0);
        else          r = os(SRC_ZERO);
      end
      SRC_SEL_IN: begin
        if (cu && cl) r = ot(T_INS);
        else if (cl)  r = os(SRC_I0);
        else          r = os(SRC_ZERO);
      end
      SRC_SEL_VSUM: begin
        if (cu && cl)      r = ot(T_VST);
        else if (cu)       r = ot(T_VCPG);
        else if (cl)       r = ot(T_VCNG);
        else               r = os(SRC_VA);
      end
      SRC_SEL_COEF: begin
        if (cu && cl)      r = ot(T_ROL);
        else if (cu || cl) r = ot(T_CF);
        else               r = os(SRC_ZERO);
      end
      SRC_SEL_I0: begin
        if (cu || cl) r = os(SRC_I0);
        else          r = os(SRC_ZERO);
      end
      default: r = o;
    endcase
    return r;
  endfunction

  function automatic q_t fetch(input opnd_t o, input q_t ram);
    q_t v;
    unique case (o.kind)
      SRC_VP:   v = in_q.positive_node_voltage;
      SRC_VN:   v = in_q.negative_node_voltage;
      SRC_VG:   v = in_q.ground_node_voltage;
      SRC_VA:   v = in_q.output_node_voltage;
      SRC_VCP:  v = vcp_q;
      SRC_VCN:  v = vcn_q;
      SRC_I0:   v = i0_q;
      SRC_SLP:  v = slp_q;
      SRC_TS:   v = q_t'({1'b0, ts_q});
      SRC_L:    v = q_t'({1'b0, l_q});
      SRC_IL:   v = q_t'({1'b0, il_q});
      SRC_R:    v = q_t'({1'b0, r_q});
      SRC_SG:   v = q_t'({1'b0, sg_q});
      SRC_LG:   v = q_t'({1'b0, lg_q});
      SRC_HALF: v = Q_HALF;
      SRC_RSW:  v = Q_RSW;
      SRC_RSWH: v = Q_RSWH;
      SRC_GSW:  v = Q_GSW;
      SRC_TMP:  v = ram;
      default:  v = '0;
    endcase
    return v;
  endfunction

  assign ra = resolve(cmd_i.uop.a, cu_q, cl_q);
  assign rb = resolve(cmd_i.uop.b, cu_q, cl_q);

  hbleg_ram #(
    .WIDTH (64),
    .DEPTH (TMP_DEPTH)
  ) u_tmp_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (cmd_i.uop.dst),
    .wdata_i   (cmd_i.mul_fin ? mul_res : alu_res),
    .raddr_a_i (ra.tmp),
    .raddr_b_i (rb.tmp),
    .rdata_a_o (ram_a),
    .rdata_b_o (ram_b)
  );

  always_comb begin
    va      = fetch(ra, ram_a);
    vb      = fetch(rb, ram_b);
    alu_res = sat_addsub(va, vb, cmd_i.uop.op == OP_SUB);
    ram_we  = cmd_i.mul_fin ||
              (cmd_i.exec && (cmd_i.uop.op == OP_ADD || cmd_i.uop.op == OP_SUB));
  end

  // diode hysteresis
  always_comb begin
    du = up_on_q ? (i0_q <= 64'sd0) : (va >= vth_q);
    dl = lo_on_q ? (i0_q >= 64'sd0) : (vb >= vth_q);
  end

  // multiplier: one 32x32 partial product per cycle, registered, then accumulated
  assign a_h = cmd_i.step[1] ? a_mag_q[63:32] : a_mag_q[31:0];
  assign b_h = cmd_i.step[0] ? b_mag_q[63:32] : b_mag_q[31:0];

  always_comb begin
    case (sh_q)
      2'd0:    pp_ext = {64'd0, prod_q};
      2'd1:    pp_ext = {32'd0, prod_q, 32'd0};
      default: pp_ext = {prod_q, 64'd0};
    endcase
  end

  always_comb begin
    fin_v = (neg_q ? ~acc_q : acc_q) + (neg_q ? RND_NEG : RND_POS);
    if (fin_v[127:95] == '0 || fin_v[127:95] == '1) begin
      mul_res = q_t'(fin_v[95:32]);
    end else begin
      mul_res = fin_v[127] ? Q_MIN : Q_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      in_q <= in_data_i;
    end
    if (cmd_i.mul_load) begin
      a_mag_q <= va[63] ? 64'(-va) : 64'(va);
      b_mag_q <= vb[63] ? 64'(-vb) : 64'(vb);
      neg_q   <= va[63] ^ vb[63];
      acc_q   <= '0;
    end
    if (cmd_i.mul_step) begin
      if (!cmd_i.step[2]) begin
        prod_q <= 64'(a_h) * 64'(b_h);
        sh_q   <= {1'b0, cmd_i.step[1]} + {1'b0, cmd_i.step[0]};
      end
      if (cmd_i.step != '0) begin
        acc_q <= acc_q + pp_ext;
      end
    end
    if (cmd_i.load_out) begin
      out_q <= '{cap_pos_voltage:         vcp_q,
                 cap_neg_voltage:         vcn_q,
                 leg_current:             i0_q,
                 pos_source_contribution: srcp_q,
                 neg_source_contribution: srcn_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= RST_ONE;
      l_q     <= RST_ONE;
      il_q    <= RST_ONE;
      r_q     <= RST_ONE;
      vth_q   <= RST_THRESHOLD;
      sg_q    <= RST_SOURCE_GAIN;
      lg_q    <= RST_ONE;
      vcp_q   <= '0;
      vcn_q   <= '0;
      i0_q    <= '0;
      slp_q   <= '0;
      srcp_q  <= '0;
      srcn_q  <= '0;
      up_on_q <= 1'b0;
      lo_on_q <= 1'b0;
      cu_q    <= 1'b0;
      cl_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_TIME_STEP:       ts_q  <= cfg_data_i[CFG_W-1:0];
          CFG_INDUCTANCE:      l_q   <= cfg_data_i[CFG_W-1:0];
          CFG_INV_INDUCTANCE:  il_q  <= cfg_data_i[CFG_W-1:0];
          CFG_LEG_RESISTANCE:  r_q   <= cfg_data_i[CFG_W-1:0];
          CFG_DIODE_THRESHOLD: vth_q <= q_t'(cfg_data_i);
          CFG_SOURCE_GAIN:     sg_q  <= cfg_data_i[CFG_W-1:0];
          CFG_LOAD_GAIN:       lg_q  <= cfg_data_i[CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.exec) begin
        unique case (cmd_i.uop.op)
          OP_DECIDE: begin
            up_on_q <= du;
            lo_on_q <= dl;
            cu_q    <= in_q.gate_upper || du;
            cl_q    <= in_q.gate_lower || dl;
          end
          OP_WR_CAP: begin
            vcp_q <= va;
            vcn_q <= vb;
          end
          OP_WR_LEG: begin
            i0_q  <= va;
            slp_q <= vb;
          end
          OP_WR_SRC: begin
            srcp_q <= va;
            srcn_q <= vb;
          end
          default: ;
        endcase
      end
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: hdl/half_bridge_leg_diode_model_step_unit.sv
// Top level of the half-bridge leg step unit: sequencer plus datapath.
//
//  port group | direction | handshake              | payload
//  -----------+-----------+------------------------+---------------------------
//  in         | input     | in_valid_i / in_ready_o | in_data_i  (hbleg_in_t)
//  out        | output    | out_valid_o/out_ready_i | out_data_o (hbleg_out_t)
//  cfg        | input     | cfg_we_i (no wait)      | cfg_idx_i, cfg_data_i
//
// A step runs from input transfer to result valid: 17 Q32.32 multiplies run
// through one shared 32x32 multiplier, which loads the operand magnitudes,
// forms and accumulates the partial products, then rounds and saturates; 27
// other microcode steps each read the scratch RAM and then execute; and the
// end-of-program fetch and the output load close the step.
// in_ready_o is high only while the sequencer is idle; a finished result waits
// in the output register, so the next item is taken while it is still pending.
// A step stalls at its end only while the previous result is not yet taken.
// Reset restores the register defaults and clears all integrator state.
module half_bridge_leg_diode_model_step_unit import hbleg_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  hbleg_in_t            in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output hbleg_out_t           out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [63:0]          cfg_data_i
);

  cmd_t cmd;

  hbleg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hbleg_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .out_data_o (out_data_o)
  );

endmodule

FILE: hdl/hbleg_checker.sv
// Port-level checks of the half-bridge leg step unit, bound to the top level.
module hbleg_checker import hbleg_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input hbleg_in_t            in_data_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input hbleg_out_t           out_data_o,
  input logic                 cfg_we_i,
  input logic [CFG_IDX_W-1:0] cfg_idx_i,
  input logic [63:0]          cfg_data_i
);

  // a pending result holds until transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed or dropped before transfer");

  // one step at a time: in_ready_o drops once an item is taken
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input taken while a step is running");

  // a new result only appears at the end of a step
  a_out_from_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result raised while the sequencer was idle");

endmodule

bind half_bridge_leg_diode_model_step_unit hbleg_checker u_hbleg_checker (.*);
